[rtl/stt_pkg.sv]
// stt_pkg: types, constants and character helpers shared by the source text tokenizer.
// No dependencies; compiled first.
package stt_pkg;

  localparam int VALUE_BITS  = 31;
  localparam int POS_BITS    = 16;
  localparam int KW_CHARS    = 6;
  localparam int KW_IDX_BITS = $clog2(KW_CHARS);
  localparam int KIND_BITS   = 5;
  localparam int ACC_W       = VALUE_BITS + 4;
  localparam int FIFO_DEPTH  = 4;
  localparam int FIFO_AW     = $clog2(FIFO_DEPTH);

  typedef logic [VALUE_BITS-1:0] value_t;
  typedef logic [POS_BITS-1:0]   pos_t;
  typedef logic [7:0]            byte_t;
  typedef logic [KW_CHARS-1:0][7:0] kwbuf_t;

  localparam value_t VALUE_MAX = '1;
  localparam pos_t   POS_MAX   = '1;

  localparam byte_t CH_QUOTE      = 8'h22;
  localparam byte_t CH_UNDERSCORE = 8'h5F;
  localparam byte_t CH_TAB        = 8'h09;
  localparam byte_t CH_NL         = 8'h0A;
  localparam byte_t CH_SPACE      = 8'h20;

  localparam logic [31:0] KW_EXIT   = "exit";
  localparam logic [23:0] KW_LET    = "let";
  localparam logic [47:0] KW_EXTERN = "extern";
  localparam logic [15:0] KW_IF     = "if";
  localparam logic [31:0] KW_ELSE   = "else";

  typedef enum logic [KIND_BITS-1:0] {
    KIND_EXIT, KIND_LET, KIND_EXTERN, KIND_IF, KIND_ELSE,
    KIND_LPAREN, KIND_RPAREN, KIND_LBRACE, KIND_RBRACE, KIND_SEMI, KIND_COLON,
    KIND_COMMA, KIND_PLUS, KIND_MINUS, KIND_STAR, KIND_SLASH, KIND_PERCENT,
    KIND_ASSIGN, KIND_INT, KIND_IDENT, KIND_STRING, KIND_EOF, KIND_ILLEGAL
  } kind_t;

  typedef enum logic [1:0] {
    MODE_IDLE, MODE_NUMBER, MODE_IDENT, MODE_STRING
  } mode_t;

  typedef struct packed {
    kind_t  kind;
    value_t int_value;
    pos_t   line;
    pos_t   column;
    pos_t   start_offset;
    pos_t   text_length;
    logic   is_last;
  } token_t;

  typedef struct packed {
    logic   push0;
    logic   push1;
    token_t tok0;
    token_t tok1;
  } push_t;

  function automatic pos_t sat_inc(pos_t v);
    return (v == POS_MAX) ? v : v + pos_t'(1);
  endfunction

  function automatic logic is_digit(byte_t c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_alpha(byte_t c);
    return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
  endfunction

  function automatic logic is_ident_start(byte_t c);
    return is_alpha(c) || (c == CH_UNDERSCORE);
  endfunction

  function automatic logic is_ident_char(byte_t c);
    return is_ident_start(c) || is_digit(c);
  endfunction

  function automatic logic is_sep(byte_t c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_NL);
  endfunction

  function automatic kind_t punct_kind(byte_t c);
    kind_t k;
    unique case (c)
      "(":     k = KIND_LPAREN;
      ")":     k = KIND_RPAREN;
      "{":     k = KIND_LBRACE;
      "}":     k = KIND_RBRACE;
      ";":     k = KIND_SEMI;
      ":":     k = KIND_COLON;
      ",":     k = KIND_COMMA;
      "+":     k = KIND_PLUS;
      "-":     k = KIND_MINUS;
      "*":     k = KIND_STAR;
      "/":     k = KIND_SLASH;
      "%":     k = KIND_PERCENT;
      "=":     k = KIND_ASSIGN;
      default: k = KIND_ILLEGAL;
    endcase
    return k;
  endfunction

  // Only the first len entries are meaningful.
  function automatic kind_t keyword_kind(kwbuf_t b, pos_t len);
    kind_t k;
    k = KIND_IDENT;
    if (len == pos_t'(4) && {b[0], b[1], b[2], b[3]} == KW_EXIT) begin
      k = KIND_EXIT;
    end else if (len == pos_t'(3) && {b[0], b[1], b[2]} == KW_LET) begin
      k = KIND_LET;
    end else if (len == pos_t'(6) &&
                 {b[0], b[1], b[2], b[3], b[4], b[5]} == KW_EXTERN) begin
      k = KIND_EXTERN;
    end else if (len == pos_t'(2) && {b[0], b[1]} == KW_IF) begin
      k = KIND_IF;
    end else if (len == pos_t'(4) && {b[0], b[1], b[2], b[3]} == KW_ELSE) begin
      k = KIND_ELSE;
    end
    return k;
  endfunction

endpackage

[rtl/stt_in_if.sv]
// stt_in_if: source byte request channel (valid/ready plus payload).
// Depends on nothing.
interface stt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       end_of_source;

  modport source (output valid, output ch, output end_of_source, input ready);
  modport sink   (input valid, input ch, input end_of_source, output ready);
endinterface

[rtl/stt_out_if.sv]
// stt_out_if: token request channel (valid/ready plus token fields).
// Depends on stt_pkg for field widths.
interface stt_out_if;
  logic                          valid;
  logic                          ready;
  logic [stt_pkg::KIND_BITS-1:0] token_kind;
  logic [stt_pkg::VALUE_BITS-1:0] int_value;
  logic [stt_pkg::POS_BITS-1:0]  line;
  logic [stt_pkg::POS_BITS-1:0]  column;
  logic [stt_pkg::POS_BITS-1:0]  start_offset;
  logic [stt_pkg::POS_BITS-1:0]  text_length;
  logic                          is_last;

  modport source (output valid, output token_kind, output int_value, output line,
                  output column, output start_offset, output text_length,
                  output is_last, input ready);
  modport sink   (input valid, input token_kind, input int_value, input line,
                  input column, input start_offset, input text_length,
                  input is_last, output ready);
endinterface

[rtl/stt_lexer.sv]
// stt_lexer: input byte register and combinational scan step with all tokenizer state.
// Depends on stt_pkg and stt_in_if; drives up to two tokens per step into the queue.
module stt_lexer (
  input  logic           clk,
  input  logic           rst_n,
  stt_in_if.sink         in_bus,
  input  logic           room,
  output stt_pkg::push_t push
);

  logic                 in_valid_r;
  stt_pkg::byte_t       ch_r;
  logic                 eos_r;

  stt_pkg::mode_t       mode_r, mode_nxt;
  stt_pkg::value_t      acc_r, acc_nxt;
  stt_pkg::kwbuf_t      kwbuf_r;
  stt_pkg::pos_t        len_r, len_nxt;
  stt_pkg::pos_t        line_r, line_nxt;
  stt_pkg::pos_t        col_r, col_nxt;
  stt_pkg::pos_t        pos_r, pos_nxt;
  stt_pkg::pos_t        sline_r, scol_r, soff_r;
  logic                 ended_r;

  logic fire;
  logic is_end, eof_path, in_str, cont_num, cont_id, scan, flush, single, have2;
  logic c_digit, c_start, c_quote, mark;
  logic kw_we;
  logic [stt_pkg::KW_IDX_BITS-1:0] kw_idx;
  logic [stt_pkg::ACC_W-1:0] acc_ext, acc_sum;
  stt_pkg::value_t acc_step;
  stt_pkg::token_t pend_tok, sec_tok;

  assign fire         = in_valid_r && room;
  assign in_bus.ready = !in_valid_r || fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_bus.ready) begin
      in_valid_r <= in_bus.valid;
    end
    if (in_bus.valid && in_bus.ready) begin
      ch_r  <= in_bus.ch;
      eos_r <= in_bus.end_of_source;
    end
  end

  // byte classification
  assign c_digit  = stt_pkg::is_digit(ch_r);
  assign c_start  = stt_pkg::is_ident_start(ch_r);
  assign c_quote  = (ch_r == stt_pkg::CH_QUOTE);
  assign is_end   = eos_r || (ch_r == 8'h00);
  assign eof_path = ended_r || is_end;
  assign in_str   = !eof_path && (mode_r == stt_pkg::MODE_STRING);
  assign cont_num = !eof_path && (mode_r == stt_pkg::MODE_NUMBER) && c_digit;
  assign cont_id  = !eof_path && (mode_r == stt_pkg::MODE_IDENT) &&
                    stt_pkg::is_ident_char(ch_r);
  assign scan     = !eof_path && !in_str && !cont_num && !cont_id;
  assign single   = scan && !stt_pkg::is_sep(ch_r) && !c_digit && !c_start && !c_quote;
  assign have2    = eof_path || single;
  assign mark     = scan && (c_digit || c_start || c_quote);
  assign flush    = eof_path ? (!ended_r && (mode_r != stt_pkg::MODE_IDLE)) :
                    in_str   ? c_quote :
                    ((mode_r == stt_pkg::MODE_NUMBER) || (mode_r == stt_pkg::MODE_IDENT)) &&
                    !cont_num && !cont_id;

  // next scan mode
  always_comb begin
    mode_nxt = mode_r;
    if (eof_path) begin
      mode_nxt = stt_pkg::MODE_IDLE;
    end else if (in_str) begin
      if (c_quote) begin
        mode_nxt = stt_pkg::MODE_IDLE;
      end
    end else if (scan) begin
      if (c_digit) begin
        mode_nxt = stt_pkg::MODE_NUMBER;
      end else if (c_start) begin
        mode_nxt = stt_pkg::MODE_IDENT;
      end else if (c_quote) begin
        mode_nxt = stt_pkg::MODE_STRING;
      end else begin
        mode_nxt = stt_pkg::MODE_IDLE;
      end
    end
  end

  // decimal accumulate with saturation
  assign acc_ext  = stt_pkg::ACC_W'(acc_r);
  assign acc_sum  = (acc_ext << 3) + (acc_ext << 1) + stt_pkg::ACC_W'(ch_r[3:0]);
  assign acc_step = (acc_sum > stt_pkg::ACC_W'(stt_pkg::VALUE_MAX)) ?
                    stt_pkg::VALUE_MAX : acc_sum[stt_pkg::VALUE_BITS-1:0];

  // datapath and tokens
  always_comb begin
    acc_nxt  = acc_r;
    len_nxt  = len_r;
    line_nxt = line_r;
    col_nxt  = col_r;
    pos_nxt  = pos_r;
    kw_we    = 1'b0;
    kw_idx   = '0;

    if (cont_num) begin
      acc_nxt = acc_step;
    end else if (scan && c_digit) begin
      acc_nxt = stt_pkg::value_t'(ch_r[3:0]);
    end

    if (cont_num || cont_id || (in_str && !c_quote)) begin
      len_nxt = stt_pkg::sat_inc(len_r);
    end else if (scan && (c_digit || c_start)) begin
      len_nxt = stt_pkg::pos_t'(1);
    end else if (scan && c_quote) begin
      len_nxt = '0;
    end

    if (cont_id && (len_r < stt_pkg::pos_t'(stt_pkg::KW_CHARS))) begin
      kw_we  = 1'b1;
      kw_idx = len_r[stt_pkg::KW_IDX_BITS-1:0];
    end else if (scan && c_start) begin
      kw_we  = 1'b1;
      kw_idx = '0;
    end

    if (!eof_path) begin
      if (ch_r == stt_pkg::CH_NL) begin
        line_nxt = stt_pkg::sat_inc(line_r);
        col_nxt  = stt_pkg::pos_t'(1);
      end else begin
        col_nxt  = stt_pkg::sat_inc(col_r);
      end
      pos_nxt = stt_pkg::sat_inc(pos_r);
    end

    pend_tok.kind         = (mode_r == stt_pkg::MODE_NUMBER) ? stt_pkg::KIND_INT :
                            (mode_r == stt_pkg::MODE_IDENT)  ?
                            stt_pkg::keyword_kind(kwbuf_r, len_r) : stt_pkg::KIND_STRING;
    pend_tok.int_value    = (mode_r == stt_pkg::MODE_NUMBER) ? acc_r : '0;
    pend_tok.line         = sline_r;
    pend_tok.column       = scol_r;
    pend_tok.start_offset = soff_r;
    pend_tok.text_length  = len_r;
    pend_tok.is_last      = !have2;

    sec_tok.kind          = eof_path ? stt_pkg::KIND_EOF : stt_pkg::punct_kind(ch_r);
    sec_tok.int_value     = '0;
    sec_tok.line          = line_r;
    sec_tok.column        = col_r;
    sec_tok.start_offset  = pos_r;
    sec_tok.text_length   = eof_path ? '0 : stt_pkg::pos_t'(1);
    sec_tok.is_last       = 1'b1;

    push.push0 = fire && (flush || have2);
    push.push1 = fire && flush && have2;
    push.tok0  = flush ? pend_tok : sec_tok;
    push.tok1  = sec_tok;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= stt_pkg::MODE_IDLE;
      acc_r   <= '0;
      len_r   <= '0;
      line_r  <= stt_pkg::pos_t'(1);
      col_r   <= stt_pkg::pos_t'(1);
      pos_r   <= '0;
      sline_r <= stt_pkg::pos_t'(1);
      scol_r  <= stt_pkg::pos_t'(1);
      soff_r  <= '0;
      ended_r <= 1'b0;
    end else if (fire) begin
      mode_r  <= mode_nxt;
      acc_r   <= acc_nxt;
      len_r   <= len_nxt;
      line_r  <= line_nxt;
      col_r   <= col_nxt;
      pos_r   <= pos_nxt;
      ended_r <= ended_r || is_end;
      if (mark) begin
        sline_r <= line_r;
        scol_r  <= col_r;
        soff_r  <= pos_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire && kw_we) begin
      kwbuf_r[kw_idx] <= ch_r;
    end
  end

`ifndef SYNTHESIS
  a_ended_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    ended_r |=> ended_r) else $error("end of source flag cleared");
  a_ended_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ended_r |-> (mode_r == stt_pkg::MODE_IDLE)) else $error("scan active after end");
  a_pair_last: assert property (@(posedge clk) disable iff (!rst_n)
    push.push1 |-> (!push.tok0.is_last && push.tok1.is_last))
    else $error("is_last misplaced on token pair");
`endif

endmodule

[rtl/stt_out_fifo.sv]
// stt_out_fifo: small token queue taking up to two tokens per cycle, one out per cycle
// while the consumer is ready. Depends on stt_pkg and stt_out_if.
module stt_out_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  stt_pkg::push_t push,
  output logic           room,
  stt_out_if.source      out_bus
);

  stt_pkg::token_t                 mem_r [stt_pkg::FIFO_DEPTH];
  logic [stt_pkg::FIFO_AW-1:0]     wp_r, rp_r;
  logic [stt_pkg::FIFO_AW:0]       cnt_r, cnt_after;
  logic                            pop;
  stt_pkg::token_t                 head;

  assign pop       = out_bus.valid && out_bus.ready;
  assign cnt_after = cnt_r - {{stt_pkg::FIFO_AW{1'b0}}, pop};
  assign room      = cnt_after <= (stt_pkg::FIFO_AW + 1)'(stt_pkg::FIFO_DEPTH - 2);

  assign head                 = mem_r[rp_r];
  assign out_bus.valid        = (cnt_r != '0);
  assign out_bus.token_kind   = head.kind;
  assign out_bus.int_value    = head.int_value;
  assign out_bus.line         = head.line;
  assign out_bus.column       = head.column;
  assign out_bus.start_offset = head.start_offset;
  assign out_bus.text_length  = head.text_length;
  assign out_bus.is_last      = head.is_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_r + stt_pkg::FIFO_AW'(push.push0) + stt_pkg::FIFO_AW'(push.push1);
      rp_r  <= rp_r + stt_pkg::FIFO_AW'(pop);
      cnt_r <= cnt_after + (stt_pkg::FIFO_AW + 1)'(push.push0)
                         + (stt_pkg::FIFO_AW + 1)'(push.push1);
    end
  end

  always_ff @(posedge clk) begin
    if (push.push0) begin
      mem_r[wp_r] <= push.tok0;
    end
    if (push.push1) begin
      mem_r[wp_r + stt_pkg::FIFO_AW'(1)] <= push.tok1;
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (stt_pkg::FIFO_AW + 1)'(stt_pkg::FIFO_DEPTH)) else $error("queue overflow");
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    push.push0 |-> room) else $error("push without room");
  a_push_order: assert property (@(posedge clk) disable iff (!rst_n)
    push.push1 |-> push.push0) else $error("second push without first");
`endif

endmodule

[rtl/source_text_tokenizer.sv]
// source_text_tokenizer: top level of the streaming source text tokenizer.
// Depends on stt_pkg, stt_in_if, stt_out_if, stt_lexer and stt_out_fifo.
//
// Takes one source byte per request and sustains one byte per cycle while the
// output queue has room. A byte is held in an input register, scanned
// combinationally against the token state, and the tokens it completes are
// written into a four-entry output queue that presents them in order. A byte
// that ends a pending number or identifier and is also a token of its own
// yields two tokens, which leave the queue one per cycle, so a long run of such
// bytes against a stalled consumer fills the queue and backpressures the input.
// Keyword matching, position counting and value accumulation all sit in the
// combinational scan step. No clearing pass is needed after reset.
module source_text_tokenizer (
  input  logic      clk,
  input  logic      rst_n,
  stt_in_if.sink    in_bus,
  stt_out_if.source out_bus
);

  stt_pkg::push_t push;
  logic           room;

  stt_lexer u_lexer (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_bus (in_bus),
    .room   (room),
    .push   (push)
  );

  stt_out_fifo u_out_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .room    (room),
    .out_bus (out_bus)
  );

endmodule
